@@ sv/vtpd_pkg.sv @@
// ----------------------------------------------------------------------------
// vtpd_pkg: shared types and constants for the vertex transform pipeline
// Fixed-point widths, payload structs, register indexes and reset values.
// ----------------------------------------------------------------------------
`default_nettype none

package vtpd_pkg;

    localparam int COORD_W  = 32;
    localparam int FRAC_W   = 16;
    // product >> FRAC_W is 2*COORD_W-FRAC_W bits; three of them plus an entry
    localparam int ACC_W    = 2 * COORD_W - FRAC_W + 3;
    localparam int QUO_W    = COORD_W + FRAC_W;
    localparam int PIPE_D   = 4 + QUO_W;
    localparam int ADDR_W   = 6;
    localparam int DATA_W   = 64;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef coord_t [3:0][3:0] mat_t;
    typedef logic signed [ACC_W-1:0] acc_t;
    typedef acc_t [3:0] acc_vec_t;
    typedef logic [ACC_W-1:0] mag_t;
    typedef logic [QUO_W-1:0] quo_t;

    typedef struct packed {
        logic signed [31:0] in_x;
        logic signed [31:0] in_y;
        logic signed [31:0] in_z;
    } in_t;

    typedef struct packed {
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic signed [31:0] out_z;
        logic               w_was_zero;
        logic               saturated;
    } out_t;

    // sideband that travels with one divide lane
    typedef struct packed {
        logic neg;
        logic ovf;
        logic wz;
    } side_t;

    typedef enum logic [2:0] {
        REG_ROW0_XY = 3'd0,
        REG_ROW0_ZW = 3'd1,
        REG_ROW1_XY = 3'd2,
        REG_ROW1_ZW = 3'd3,
        REG_ROW2_XY = 3'd4,
        REG_ROW2_ZW = 3'd5,
        REG_ROW3_XY = 3'd6,
        REG_ROW3_ZW = 3'd7
    } reg_idx_t;

    localparam logic [DATA_W-1:0] RST_ROW0_XY = 64'h0000_0000_0001_0000;
    localparam logic [DATA_W-1:0] RST_ROW0_ZW = 64'h0;
    localparam logic [DATA_W-1:0] RST_ROW1_XY = 64'h0001_0000_0000_0000;
    localparam logic [DATA_W-1:0] RST_ROW1_ZW = 64'h0;
    localparam logic [DATA_W-1:0] RST_ROW2_XY = 64'h0;
    localparam logic [DATA_W-1:0] RST_ROW2_ZW = 64'h0000_0000_0001_0000;
    localparam logic [DATA_W-1:0] RST_ROW3_XY = 64'h0;
    localparam logic [DATA_W-1:0] RST_ROW3_ZW = 64'h0001_0000_0000_0000;

endpackage

`default_nettype wire

@@ sv/vertex_transform_perspective_divide_top.sv @@
// ----------------------------------------------------------------------------
// vertex_transform_perspective_divide_top: 4x4 transform and divide by w
// Takes one Q16.16 point per word, transforms it by the configured matrix and
// divides x, y, z by w with saturation.
//
// Input words (in_data) are taken when in_valid is high and in_stall is low;
// result words leave on out_data under out_valid / out_stall the same way.
// A new point can enter every cycle while in_stall is low: throughput is
// then one word per cycle. From acceptance to out_valid a word passes the
// multiply and sum registers, the sign and magnitude stage, the divide
// stages (one quotient bit per stage) and the clamp into the output register.
// The whole pipeline advances together; it holds only when a result word
// sits in the output register and out_stall is high, and then in_stall is
// raised, so nothing is dropped or repeated.
// The matrix lives in eight 64-bit APB registers at byte address 8*i. Reset
// loads the identity matrix and clears all valid bits. Write the matrix only
// while no point is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module vertex_transform_perspective_divide_top (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire vtpd_pkg::in_t                 in_data,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output vtpd_pkg::out_t                     out_data,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [vtpd_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [vtpd_pkg::DATA_W-1:0]   pwdata,
    output logic [vtpd_pkg::DATA_W-1:0]        prdata,
    output logic                               pready
);
    import vtpd_pkg::*;

    localparam logic [QUO_W-1:0] MAX_POS = QUO_W'((64'd1 << (COORD_W - 1)) - 64'd1);
    localparam logic [QUO_W-1:0] MAX_NEG = QUO_W'(64'd1 << (COORD_W - 1));

    logic [DATA_W-1:0] cfg_reg [8];
    reg_idx_t          widx;
    logic              wr_en;
    mat_t              mat;

    logic              adv;
    logic [PIPE_D-1:0] vld_reg;
    logic [PIPE_D-1:0] vld_next;
    logic              out_vld_reg;
    out_t              out_reg;
    out_t              out_next;

    acc_vec_t          acc;
    mag_t              n_reg [3];
    mag_t              n_next [3];
    mag_t              d_reg;
    mag_t              d_next;
    side_t             sd_reg [3];
    side_t             sd_next [3];
    logic              wz;

    quo_t              q [3];
    side_t             q_sd [3];
    logic              sat_k [3];
    coord_t            res_k [3];
    logic [QUO_W:0]    neg_q;

    // ---------------- configuration port ----------------
    assign pready = 1'b1;
    assign widx   = reg_idx_t'(paddr[ADDR_W-1:3]);
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg[REG_ROW0_XY] <= RST_ROW0_XY;
            cfg_reg[REG_ROW0_ZW] <= RST_ROW0_ZW;
            cfg_reg[REG_ROW1_XY] <= RST_ROW1_XY;
            cfg_reg[REG_ROW1_ZW] <= RST_ROW1_ZW;
            cfg_reg[REG_ROW2_XY] <= RST_ROW2_XY;
            cfg_reg[REG_ROW2_ZW] <= RST_ROW2_ZW;
            cfg_reg[REG_ROW3_XY] <= RST_ROW3_XY;
            cfg_reg[REG_ROW3_ZW] <= RST_ROW3_ZW;
        end
        else if (wr_en)
        begin
            cfg_reg[widx] <= pwdata;
        end
    end

    always_comb
    begin
        unique case (widx)
            REG_ROW0_XY: prdata = cfg_reg[REG_ROW0_XY];
            REG_ROW0_ZW: prdata = cfg_reg[REG_ROW0_ZW];
            REG_ROW1_XY: prdata = cfg_reg[REG_ROW1_XY];
            REG_ROW1_ZW: prdata = cfg_reg[REG_ROW1_ZW];
            REG_ROW2_XY: prdata = cfg_reg[REG_ROW2_XY];
            REG_ROW2_ZW: prdata = cfg_reg[REG_ROW2_ZW];
            REG_ROW3_XY: prdata = cfg_reg[REG_ROW3_XY];
            REG_ROW3_ZW: prdata = cfg_reg[REG_ROW3_ZW];
            default:     prdata = '0;
        endcase
    end

    always_comb
    begin
        for (int r = 0; r < 4; r++)
        begin
            for (int c = 0; c < 4; c++)
            begin
                mat[r][c] = cfg_reg[r*2 + c/2][32*(c%2) +: COORD_W];
            end
        end
    end

    // ---------------- pipeline control ----------------
    assign adv      = !(out_vld_reg && out_stall);
    assign in_stall = !adv;
    assign vld_next = {vld_reg[PIPE_D-2:0], in_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg     <= '0;
            out_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg     <= vld_next;
            out_vld_reg <= vld_reg[PIPE_D-1];
        end
    end

    // ---------------- multiply and sum ----------------
    vtpd_mac u_mac (
        .clk (clk),
        .en  (adv),
        .pt  (in_data),
        .mat (mat),
        .acc (acc)
    );

    // ---------------- sign and magnitude ----------------
    always_comb
    begin
        wz = (acc[3] == '0);
        // zero w: divide by one in fixed point, which passes x, y, z through
        d_next = wz ? mag_t'(1) << FRAC_W
                    : (acc[3][ACC_W-1] ? mag_t'(-acc[3]) : mag_t'(acc[3]));
        for (int k = 0; k < 3; k++)
        begin
            n_next[k]      = acc[k][ACC_W-1] ? mag_t'(-acc[k]) : mag_t'(acc[k]);
            sd_next[k].neg = acc[k][ACC_W-1] ^ (!wz && acc[3][ACC_W-1]);
            sd_next[k].ovf = 1'b0;
            sd_next[k].wz  = wz;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            n_reg  <= n_next;
            d_reg  <= d_next;
            sd_reg <= sd_next;
        end
    end

    // ---------------- divide lanes ----------------
    for (genvar k = 0; k < 3; k++)
    begin : g_lane
        vtpd_div u_div (
            .clk  (clk),
            .en   (adv),
            .n    (n_reg[k]),
            .d    (d_reg),
            .sd   (sd_reg[k]),
            .q    (q[k]),
            .q_sd (q_sd[k])
        );
    end

    // ---------------- clamp ----------------
    always_comb
    begin
        neg_q = '0;
        for (int k = 0; k < 3; k++)
        begin
            sat_k[k] = q_sd[k].ovf
                    || (!q_sd[k].neg && (q[k] > MAX_POS))
                    || ( q_sd[k].neg && (q[k] > MAX_NEG));
            neg_q    = (QUO_W+1)'(0) - {1'b0, q[k]};
            if (sat_k[k])
            begin
                res_k[k] = q_sd[k].neg ? coord_t'(MAX_NEG) : coord_t'(MAX_POS);
            end
            else
            begin
                res_k[k] = q_sd[k].neg ? neg_q[COORD_W-1:0] : q[k][COORD_W-1:0];
            end
        end
        out_next.out_x      = 32'(res_k[0]);
        out_next.out_y      = 32'(res_k[1]);
        out_next.out_z      = 32'(res_k[2]);
        out_next.w_was_zero = q_sd[0].wz;
        out_next.saturated  = sat_k[0] || sat_k[1] || sat_k[2];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_reg <= out_next;
        end
    end

    assign out_valid = out_vld_reg;
    assign out_data  = out_reg;

endmodule

`default_nettype wire

@@ sv/vtpd_mac.sv @@
// ----------------------------------------------------------------------------
// vtpd_mac: matrix multiply of one point
// Three stages: products, pairwise sums, final sum of each column.
// ----------------------------------------------------------------------------
`default_nettype none

module vtpd_mac (
    input  wire logic              clk,
    input  wire logic              en,
    input  wire vtpd_pkg::in_t     pt,
    input  wire vtpd_pkg::mat_t    mat,
    output vtpd_pkg::acc_vec_t     acc
);
    import vtpd_pkg::*;

    logic signed [2*COORD_W-1:0] prod_reg [3][4];
    logic signed [2*COORD_W-1:0] prod_next [3][4];
    acc_t                        pa_reg [4];
    acc_t                        pb_reg [4];
    acc_t                        pa_next [4];
    acc_t                        pb_next [4];
    acc_vec_t                    acc_reg;
    acc_vec_t                    acc_next;
    coord_t                      p [3];

    always_comb
    begin
        p[0] = $signed(pt.in_x[COORD_W-1:0]);
        p[1] = $signed(pt.in_y[COORD_W-1:0]);
        p[2] = $signed(pt.in_z[COORD_W-1:0]);
        for (int k = 0; k < 3; k++)
        begin
            for (int c = 0; c < 4; c++)
            begin
                prod_next[k][c] = $signed(p[k]) * $signed(mat[k][c]);
            end
        end
        for (int c = 0; c < 4; c++)
        begin
            // arithmetic shift floors toward minus infinity
            pa_next[c] = ACC_W'(prod_reg[0][c] >>> FRAC_W)
                       + ACC_W'(prod_reg[1][c] >>> FRAC_W);
            pb_next[c] = ACC_W'(prod_reg[2][c] >>> FRAC_W)
                       + ACC_W'($signed(mat[3][c]));
            acc_next[c] = pa_reg[c] + pb_reg[c];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= prod_next;
            pa_reg   <= pa_next;
            pb_reg   <= pb_next;
            acc_reg  <= acc_next;
        end
    end

    assign acc = acc_reg;

endmodule

`default_nettype wire

@@ sv/vtpd_div.sv @@
// ----------------------------------------------------------------------------
// vtpd_div: pipelined restoring divider, one quotient bit per stage
// Forms floor(n * 2^FRAC_W / d) and flags a quotient that overflows.
// ----------------------------------------------------------------------------
`default_nettype none

module vtpd_div (
    input  wire logic            clk,
    input  wire logic            en,
    input  wire vtpd_pkg::mag_t  n,
    input  wire vtpd_pkg::mag_t  d,
    input  wire vtpd_pkg::side_t sd,
    output vtpd_pkg::quo_t       q,
    output vtpd_pkg::side_t      q_sd
);
    import vtpd_pkg::*;

    mag_t  rem_reg [QUO_W];
    quo_t  nq_reg  [QUO_W];
    mag_t  d_reg   [QUO_W];
    side_t sd_reg  [QUO_W];

    mag_t  rem_in  [QUO_W];
    quo_t  nq_in   [QUO_W];
    mag_t  d_in    [QUO_W];
    side_t sd_in   [QUO_W];
    mag_t  rem_next [QUO_W];
    quo_t  nq_next  [QUO_W];

    logic [ACC_W:0] t;
    logic           ge;
    mag_t           rem0;

    always_comb
    begin
        rem0 = n >> COORD_W;
        for (int i = 0; i < QUO_W; i++)
        begin
            if (i == 0)
            begin
                rem_in[i] = rem0;
                nq_in[i]  = {n[COORD_W-1:0], {FRAC_W{1'b0}}};
                d_in[i]   = d;
                sd_in[i]  = sd;
                // whole part of n/d already needs more than COORD_W bits
                sd_in[i].ovf = (rem0 >= d);
            end
            else
            begin
                rem_in[i] = rem_reg[i-1];
                nq_in[i]  = nq_reg[i-1];
                d_in[i]   = d_reg[i-1];
                sd_in[i]  = sd_reg[i-1];
            end
        end
        t  = '0;
        ge = 1'b0;
        for (int i = 0; i < QUO_W; i++)
        begin
            t  = {rem_in[i], nq_in[i][QUO_W-1]};
            ge = (t >= {1'b0, d_in[i]});
            rem_next[i] = ge ? ACC_W'(t - {1'b0, d_in[i]}) : t[ACC_W-1:0];
            nq_next[i]  = {nq_in[i][QUO_W-2:0], ge};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < QUO_W; i++)
            begin
                rem_reg[i] <= rem_next[i];
                nq_reg[i]  <= nq_next[i];
                d_reg[i]   <= d_in[i];
                sd_reg[i]  <= sd_in[i];
            end
        end
    end

    assign q    = nq_reg[QUO_W-1];
    assign q_sd = sd_reg[QUO_W-1];

endmodule

`default_nettype wire

@@ sv/vtpd_checker.sv @@
// ----------------------------------------------------------------------------
// vtpd_checker: port-level checks for the vertex transform block
// Watches flow control and the saturation flag on the top level's ports.
// ----------------------------------------------------------------------------
`default_nettype none

module vtpd_checker (
    input wire logic           clk,
    input wire logic           rst_n,
    input wire logic           in_stall,
    input wire logic           out_valid,
    input wire logic           out_stall,
    input wire vtpd_pkg::out_t out_data
);
    import vtpd_pkg::*;

    // stall input only when a result word is held back
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("input stalled without a held output word");

    // held output word stays put
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
        else $error("stalled output word changed");

    // a saturated word shows a clamped component
    a_sat_value: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.saturated) |->
            (out_data.out_x == 32'sh7fffffff || out_data.out_x == 32'sh80000000 ||
             out_data.out_y == 32'sh7fffffff || out_data.out_y == 32'sh80000000 ||
             out_data.out_z == 32'sh7fffffff || out_data.out_z == 32'sh80000000))
        else $error("saturated flag without a clamped component");

endmodule

bind vertex_transform_perspective_divide_top vtpd_checker u_vtpd_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);

`default_nettype wire
